### hw/rtl/pcm_s16_pkg.sv
// Package for the PCM to signed 16-bit converter.
// Holds the format codes and the float conversion helper; no dependencies.
`timescale 1ns / 1ps
package pcm_s16_pkg;
    typedef enum logic [2:0] {
        FMT_U8  = 3'd0,
        FMT_S16 = 3'd1,
        FMT_S32 = 3'd2,
        FMT_F32 = 3'd3,
        FMT_F64 = 3'd4
    } t_fmt;

    localparam int MAN_W = 52;

    // sign, biased exponent (11 bits, double bias), mantissa (52 bits, double layout)
    typedef struct packed {
        logic        sgn;
        logic [10:0] expo;
        logic [MAN_W-1:0] man;
    } t_flt;

    function automatic logic signed [15:0] flt_to_s16(input t_flt f);
        logic [MAN_W:0] sig;
        logic [67:0]    sh;
        logic [16:0]    ipart;
        logic           half;
        logic           sticky;
        logic [17:0]    mag;
        logic [11:0]    e;
        logic [5:0]     amt;
        logic signed [15:0] res;
        sig = {(f.expo != 11'd0), f.man};
        // value*32768 = sig * 2^(expo-1023-52+15); integer part when shifting
        // sig left by (expo-1023-52+15+MAN_W... ) done via window below
        e = {1'b0, f.expo};
        res = '0;
        ipart = '0;
        half = 1'b0;
        sticky = 1'b0;
        sh = '0;
        amt = '0;
        if (f.expo == 11'h7FF) begin
            res = (f.man != '0) ? 16'sd0 : (f.sgn ? 16'sh8000 : 16'sd32767);
        end else if (e >= 12'd1024) begin
            // |x| >= 2 -> scaled >= 65536
            res = f.sgn ? 16'sh8000 : 16'sd32767;
        end else begin
            // scaled = sig * 2^(e-1060); place in 68-bit window with 52 frac bits
            // sh = sig << (e-1008) for e in [1008,1023]; ipart=sh[67:52]
            if (e >= 12'd1008) begin
                amt = 6'(e - 12'd1008);
                sh = {15'd0, sig} << amt;
                ipart = {1'b0, sh[67:52]};
                half = sh[51];
                sticky = |sh[50:0];
            end else if (e >= 12'd959) begin
                // tiny: ipart 0, shift right
                amt = 6'(12'd1008 - e);
                sh = {15'd0, sig} >> amt;
                half = sh[51];
                sticky = (|sh[50:0]) || ((({15'd0, sig} << (7'd68 - {1'b0, amt})) != '0)
                          && (amt != 6'd0));
            end else begin
                sticky = (f.expo != '0) || (f.man != '0);
            end
            mag = {1'b0, ipart} + 18'(half && (sticky || ipart[0]));
            if (f.sgn) begin
                res = (mag >= 18'd32768) ? 16'sh8000 : -$signed(16'(mag));
            end else begin
                res = (mag >= 18'd32767) ? 16'sd32767 : $signed(16'(mag));
            end
        end
        return res;
    endfunction
endpackage

### hw/rtl/pcm_s16_conv.sv
// Combinational sample conversion for the PCM to s16 converter.
// Depends on pcm_s16_pkg.
`timescale 1ns / 1ps
module pcm_s16_conv import pcm_s16_pkg::*; (
    input  logic [2:0]         i_operation,
    input  logic [63:0]        i_raw_sample,
    input  logic               i_invert,
    output logic signed [15:0] o_pcm
);
    t_flt f;
    always_comb begin
        f = '0;
        case (i_operation)
            FMT_F32: begin
                f.sgn  = i_raw_sample[31] ^ i_invert;
                f.man  = {i_raw_sample[22:0], 29'd0};
                if (i_raw_sample[30:23] == 8'hFF) f.expo = 11'h7FF;
                else if (i_raw_sample[30:23] == 8'd0) f.expo = 11'd0;
                else f.expo = 11'({3'd0, i_raw_sample[30:23]} + 11'd896);
            end
            default: begin
                f.sgn  = i_raw_sample[63];
                f.expo = i_raw_sample[62:52];
                f.man  = i_raw_sample[51:0];
            end
        endcase
    end
    always_comb begin
        case (i_operation)
            FMT_U8:  o_pcm = $signed({i_raw_sample[7] ^ 1'b1, i_raw_sample[6:0], 8'd0});
            FMT_S16: o_pcm = $signed(i_raw_sample[15:0]);
            FMT_S32: o_pcm = $signed(i_raw_sample[31:16]);
            FMT_F32, FMT_F64: o_pcm = flt_to_s16(f);
            default: o_pcm = '0;
        endcase
    end
endmodule

### hw/rtl/pcm_format_to_s16.sv
// Top level of the PCM sample format to signed 16-bit converter.
// Depends on pcm_s16_pkg and pcm_s16_conv.
//
// Usage:
//   Input channel: i_valid / o_stall with i_operation (format code) and
//   i_raw_sample. Output channel: o_valid / i_stall with o_pcm_out.
//   A transfer happens on a rising edge with valid high and stall low.
//   i_cfg_we writes i_cfg_data as the invert flag for single floats.
//   Pipeline: input register, then result register.
//   Throughput: one sample per cycle while the receiver does not stall.
//   On stall, a full result register holds, and a full input register
//   holds while the result register is full; o_stall rises only then.
//   Reset (synchronous, i_rst_n low) empties both stages and clears
//   the invert flag.
`timescale 1ns / 1ps
module pcm_format_to_s16 import pcm_s16_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic [63:0]        i_raw_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_pcm_out
);
    logic r_inv, r_v1, r_v2;
    logic [2:0] r_op;
    logic [63:0] r_raw;
    logic signed [15:0] r_pcm, n_pcm;
    logic adv2, adv1;

    assign adv2 = !r_v2 || !i_stall;
    assign adv1 = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v2;
    assign o_pcm_out = r_pcm;

    pcm_s16_conv u_conv (
        .i_operation (r_op),
        .i_raw_sample(r_raw),
        .i_invert    (r_inv),
        .o_pcm       (n_pcm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_cfg_we) r_inv <= i_cfg_data;
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_op  <= i_operation;
            r_raw <= i_raw_sample;
        end
        if (adv2 && r_v1) r_pcm <= n_pcm;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && i_stall |=> r_v2 && $stable(r_pcm)) else $error("result lost");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1 && r_v2 && i_stall) else $error("bad stall");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !i_stall |=> r_v2) else $error("item dropped");
endmodule

### verif/tb_top.sv
// Self-checking bench for pcm_format_to_s16: directed and random samples in all formats,
// random idles on both channels, invert flag toggled between phases.
// Depends on pcm_s16_pkg and the converter RTL.
`timescale 1ns / 1ps
module tb_top;
    import pcm_s16_pkg::*;

    class pcm_scoreboard;
        bit                 invert;
        logic signed [15:0] pending[$];
        int                 errors;
        int                 checked;

        function int round_sat(real x);
            int  t;
            real f;
            if (x != x) return 0;
            if (x >= 32767.0) return 32767;
            if (x <= -32768.0) return -32768;
            t = $rtoi(x);
            f = x - t;
            if (x >= 0.0) begin
                if (f > 0.5 || (f == 0.5 && t[0])) t++;
            end else begin
                if (f < -0.5 || (f == -0.5 && t[0])) t--;
            end
            return t;
        endfunction

        function real single_value(logic [31:0] w);
            real m;
            if (w[30:23] == 8'hFF) begin
                if (w[22:0] != 0) m = $bitstoreal(64'h7FF8_0000_0000_0000);
                else m = $bitstoreal(64'h7FF0_0000_0000_0000);
            end else if (w[30:23] == 0) begin
                m = w[22:0] * (2.0 ** -149);
            end else begin
                m = $bitstoreal({1'b0, 11'(w[30:23] + 11'd896), w[22:0], 29'd0});
            end
            return w[31] ? -m : m;
        endfunction

        function void note(t_fmt op, logic [63:0] raw);
            logic [15:0] v;
            real         s;
            case (op)
                FMT_U8:  v = {raw[7:0] ^ 8'h80, 8'h00};
                FMT_S16: v = raw[15:0];
                FMT_S32: v = raw[31:16];
                FMT_F32: begin
                    s = single_value(raw[31:0]) * 32768.0;
                    if (invert) s = -s;
                    v = 16'(round_sat(s));
                end
                FMT_F64: v = 16'(round_sat($bitstoreal(raw) * 32768.0));
                default: v = '0;
            endcase
            pending.push_back(v);
        endfunction

        function void check(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending.size() == 0) begin
                $error("pcm_out: unexpected result %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                $error("pcm_out: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_operation;
    logic [63:0]        i_raw_sample;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_pcm_out;

    pcm_scoreboard sb;
    int            cycles;
    int            stall_left;
    bit            quiet;
    int            sent;

    pcm_format_to_s16 u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_raw_sample (i_raw_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pcm_out    (o_pcm_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check(o_pcm_out);
            stall_left = quiet ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    task automatic send(input logic [2:0] op, input logic [63:0] raw);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_operation  = op;
        i_raw_sample = raw;
        do @(posedge i_clk); while (o_stall);
        sb.note(t_fmt'(op), raw);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_config(input bit inv);
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = inv;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.invert  = inv;
    endtask

    function automatic logic [63:0] rand_item(output logic [2:0] op);
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick < 2) op = 3'($urandom_range(5, 7));
        else if (pick < 5) op = 3'($urandom_range(0, 2));
        else if (pick < 12) op = FMT_F32;
        else op = FMT_F64;
        if (op == FMT_F32 && $urandom_range(0, 3) != 0)
            raw[30:23] = 8'($urandom_range(100, 129));
        if (op == FMT_F64 && $urandom_range(0, 3) != 0)
            raw[62:52] = 11'($urandom_range(990, 1025));
        return raw;
    endfunction

    task automatic directed();
        send(FMT_U8,  64'hFFFF_FFFF_FFFF_FF00);
        send(FMT_U8,  64'h0000_0000_0000_00FF);
        send(FMT_U8,  64'h0000_0000_0000_0080);
        send(FMT_S16, 64'hAAAA_AAAA_AAAA_7FFF);
        send(FMT_S16, 64'h0000_0000_0000_8000);
        send(FMT_S32, 64'hFFFF_FFFF_8000_FFFF);
        send(FMT_S32, 64'h0000_0000_7FFF_0000);
        send(FMT_F32, 64'hFFFF_FFFF_3F80_0000);
        send(FMT_F32, 64'h0000_0000_BF80_0000);
        send(FMT_F32, 64'h0000_0000_3780_0000);
        send(FMT_F32, 64'h0000_0000_37C0_0000);
        send(FMT_F32, 64'h0000_0000_7F80_0000);
        send(FMT_F32, 64'h0000_0000_FF80_0000);
        send(FMT_F32, 64'h0000_0000_FFC0_0001);
        send(FMT_F32, 64'h0000_0000_8000_0001);
        send(FMT_F32, 64'h0000_0000_7F7F_FFFF);
        send(FMT_F64, 64'h3FEF_FFC0_0000_0000);
        send(FMT_F64, 64'hBFF0_0000_0000_0000);
        send(FMT_F64, 64'h3EF0_0000_0000_0000);
        send(FMT_F64, 64'hBEF8_0000_0000_0000);
        send(FMT_F64, 64'hFFF0_0000_0000_0000);
        send(FMT_F64, 64'h7FF8_0000_0000_0001);
        send(FMT_F64, 64'h0000_0000_0000_0001);
        send(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        send(3'd7, 64'h1234_5678_9ABC_DEF0);
    endtask

    initial begin
        logic [2:0]  op;
        logic [63:0] raw;
        sb           = new();
        cycles       = 0;
        stall_left   = 0;
        quiet        = 1'b0;
        sent         = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = 1'b0;
        i_valid      = 1'b0;
        i_operation  = '0;
        i_raw_sample = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        directed();
        drain_and_config(1'b1);
        directed();
        for (int phase = 0; phase < 4; phase++) begin
            drain_and_config(phase[0]);
            quiet = (phase == 2);
            repeat (250) begin
                raw = rand_item(op);
                send(op, raw);
            end
        end
        quiet   = 1'b0;
        i_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        $display("Covered %0d samples in all formats, both invert settings, %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
